// ----- src/bfs_pkg.sv -----
// Shared types, constants and digit arithmetic helpers for the BCD fixed-point scaler.
package bfs_pkg;

    // Default digit counts of the stored number.
    localparam int INT_LEN_DEF  = 512;
    localparam int FRAC_LEN_DEF = 1024;

    // Width of the binary load value and the BCD digits it can produce.
    localparam int LOAD_BITS  = 64;
    localparam int LOAD_CNT_W = $clog2(LOAD_BITS);
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    // Request codes.
    typedef enum logic [2:0] {
        REQ_LOAD  = 3'd0,
        REQ_MUL   = 3'd1,
        REQ_DIV   = 3'd2,
        REQ_ROUND = 3'd3,
        REQ_READ  = 3'd4
    } req_code_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CONV,
        ST_WALK,
        ST_READ,
        ST_DONE
    } state_t;

    // One double-dabble correction: every BCD digit of five or more gains three.
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (v[4*i +: 4] >= 4'd5)
            begin
                r[4*i +: 4] = v[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    // Quotient of a small value by ten through a reciprocal multiply (exact below 160).
    function automatic logic [3:0] div10(input logic [7:0] t);
        logic [15:0] prod;
        prod = 16'(t) * 16'd205;
        return prod[14:11];
    endfunction

    // Quotient of a small value by a 4-bit divisor, four restoring steps.
    // The caller guarantees the quotient stays below sixteen.
    function automatic logic [3:0] div_small(input logic [7:0] t, input logic [3:0] f);
        logic [7:0]  r;
        logic [11:0] sub;
        logic [3:0]  q;
        r = t;
        q = 4'd0;
        for (int i = 3; i >= 0; i--)
        begin
            sub = 12'(f) << i;
            if (12'(r) >= sub)
            begin
                r    = r - sub[7:0];
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

// ----- src/bfs_req_if.sv -----
// Request channel of the BCD fixed-point scaler.
interface bfs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [63:0] load_value;
    logic [3:0]  factor;
    logic [10:0] precision;
    logic [10:0] position;

    modport source (output valid, req_type, load_value, factor, precision, position,
                    input ready);
    modport sink   (input valid, req_type, load_value, factor, precision, position,
                    output ready);
endinterface

// ----- src/bfs_rsp_if.sv -----
// Result channel of the BCD fixed-point scaler.
interface bfs_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit;
    logic [8:0] leading_zeros;

    modport source (output valid, digit, leading_zeros, input ready);
    modport sink   (input valid, digit, leading_zeros, output ready);
endinterface

// ----- src/bcd_fixed_point_scaler_core.sv -----
// Top level of the BCD fixed-point scaler: digit store, digit walker and result register.
//
//  Channel | Direction | Handshake     | Payload
//  --------+-----------+---------------+-------------------------------------------------
//  req     | in        | valid / ready | req_type, load_value, factor, precision, position
//  rsp     | out       | valid / ready | digit, leading_zeros
//
// With TOTAL = INT_LEN + FRAC_LEN, multiply, divide and round walk all TOTAL digits: one
// shared digit unit walks the digit memory, which has one read and one write port, one digit
// a cycle. A divide by zero or a round to FRAC_LEN or more fraction digits finishes at once.
// A load first converts its binary value to BCD by double dabble. One request at a time.
// A read goes through a read state. After reset a clearing pass writes zero to every digit.
// A waiting result does not stop the next request being taken, but a finished request
// waits in its last state until the output register is free.
module bcd_fixed_point_scaler_core #(
    parameter int INT_LEN  = bfs_pkg::INT_LEN_DEF,
    parameter int FRAC_LEN = bfs_pkg::FRAC_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bfs_req_if.sink   req,
    bfs_rsp_if.source rsp
);

    localparam int TOTAL = INT_LEN + FRAC_LEN;
    localparam int AW    = $clog2(TOTAL);
    localparam int LZW   = $clog2(INT_LEN);
    localparam int CW    = AW + 12;

    localparam logic [AW-1:0]  INT_A   = AW'(INT_LEN);
    localparam logic [AW-1:0]  LAST_A  = AW'(TOTAL - 1);
    localparam logic [AW:0]    TOTAL_N = (AW + 1)'(TOTAL);
    localparam logic [LZW-1:0] LZ_MAX  = LZW'(INT_LEN - 1);
    localparam logic [CW-1:0]  TOTAL_C = CW'(TOTAL);
    localparam logic [CW-1:0]  FRACT_C = CW'(FRAC_LEN);
    localparam logic [CW-1:0]  INT_C   = CW'(INT_LEN);

    // Sequencer and walk registers.
    bfs_pkg::state_t    state_reg, state_next;
    bfs_pkg::req_code_t op_reg, op_next;
    logic [3:0]         factor_reg, factor_next;
    logic [AW-1:0]      pa_reg, pa_next;
    logic [AW-1:0]      walk_addr_reg, walk_addr_next;
    logic [AW:0]        walk_left_reg, walk_left_next;
    logic               down_reg, down_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [AW-1:0]      s1_addr_reg, s1_addr_next;
    logic [3:0]         carry_reg, carry_next;
    logic [bfs_pkg::LOAD_BITS-1:0]  bin_reg, bin_next;
    logic [bfs_pkg::BCD_W-1:0]      bcd_reg, bcd_next;
    logic [bfs_pkg::LOAD_CNT_W-1:0] conv_cnt_reg, conv_cnt_next;
    logic [LZW-1:0]     lz_reg, lz_next;
    logic [3:0]         digit_reg, digit_next;
    logic               in_range_reg, in_range_next;
    logic               out_valid_reg, out_valid_next;
    logic [3:0]         out_digit_reg, out_digit_next;
    logic [8:0]         out_lz_reg, out_lz_next;

    // Digit memory: integer digits most significant first, then fraction digits.
    logic [3:0]    mem [TOTAL];
    logic [3:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [3:0]    wr_data;

    // Shared digit unit outputs.
    logic          s1_is_int;
    logic [3:0]    s1_wdata;
    logic [3:0]    s1_carry;
    logic [7:0]    mul_t;
    logic [3:0]    mul_q;
    logic [7:0]    div_t;
    logic [3:0]    div_q;
    logic [4:0]    rnd_t;

    // Widened request fields.
    logic [CW-1:0]      pos_c;
    logic [CW-1:0]      prec_c;
    logic [CW-1:0]      pa_c;
    logic [LZW+8:0]     lz_ext;
    logic               accept;

    assign accept = req.valid && req.ready;
    assign pos_c  = CW'(req.position);
    assign prec_c = CW'(req.precision);
    assign pa_c   = INT_C + prec_c;
    assign lz_ext = {9'd0, lz_reg};

    assign req.ready         = (state_reg == bfs_pkg::ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.digit         = out_digit_reg;
    assign rsp.leading_zeros = out_lz_reg;

    // Memory port: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Shared digit unit: one read-modify-write step of the current request.
    always_comb
    begin
        s1_is_int = (s1_addr_reg < INT_A);
        mul_t = 8'(rd_data_reg) * 8'(factor_reg) + 8'(carry_reg);
        mul_q = bfs_pkg::div10(mul_t);
        div_t = (8'(carry_reg) << 3) + (8'(carry_reg) << 1) + 8'(rd_data_reg);
        div_q = bfs_pkg::div_small(div_t, factor_reg);
        rnd_t = 5'(rd_data_reg) + 5'(carry_reg);
        s1_wdata = rd_data_reg;
        s1_carry = carry_reg;
        case (op_reg)
            bfs_pkg::REQ_LOAD:
            begin
                s1_wdata = s1_is_int ? bcd_reg[3:0] : 4'd0;
            end
            bfs_pkg::REQ_MUL:
            begin
                s1_wdata = 4'(mul_t - 8'(mul_q) * 8'd10);
                s1_carry = mul_q;
            end
            bfs_pkg::REQ_DIV:
            begin
                s1_wdata = div_q;
                s1_carry = 4'(div_t - 8'(div_q) * 8'(factor_reg));
            end
            bfs_pkg::REQ_ROUND:
            begin
                if (s1_addr_reg > pa_reg)
                begin
                    s1_wdata = 4'd0;
                end
                else if (s1_addr_reg == pa_reg)
                begin
                    // The first dropped digit decides the round-up carry.
                    s1_wdata = 4'd0;
                    s1_carry = (rd_data_reg >= 4'd5) ? 4'd1 : 4'd0;
                end
                else if (rnd_t >= 5'd10)
                begin
                    s1_wdata = 4'(rnd_t - 5'd10);
                    s1_carry = 4'd1;
                end
                else
                begin
                    s1_wdata = 4'(rnd_t);
                    s1_carry = 4'd0;
                end
            end
            default:
            begin
                s1_wdata = rd_data_reg;
            end
        endcase
    end

    // Sequencer: next state and outputs.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        factor_next    = factor_reg;
        pa_next        = pa_reg;
        walk_addr_next = walk_addr_reg;
        walk_left_next = walk_left_reg;
        down_next      = down_reg;
        s1_valid_next  = 1'b0;
        s1_addr_next   = s1_addr_reg;
        carry_next     = carry_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        conv_cnt_next  = conv_cnt_reg;
        lz_next        = lz_reg;
        digit_next     = digit_reg;
        in_range_next  = in_range_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_digit_next = out_digit_reg;
        out_lz_next    = out_lz_reg;
        rd_addr        = walk_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = walk_addr_reg;
        wr_data        = 4'd0;

        unique case (state_reg)
            bfs_pkg::ST_CLEAR:
            begin
                // Clearing pass after reset, one digit a cycle.
                if (walk_left_reg != '0)
                begin
                    wr_en          = 1'b1;
                    walk_addr_next = walk_addr_reg + 1'b1;
                    walk_left_next = walk_left_reg - 1'b1;
                end
                else
                begin
                    state_next = bfs_pkg::ST_IDLE;
                end
            end
            bfs_pkg::ST_IDLE:
            begin
                rd_addr = pos_c[AW-1:0];
                if (accept)
                begin
                    digit_next     = 4'd0;
                    factor_next    = req.factor;
                    carry_next     = 4'd0;
                    lz_next        = LZ_MAX;
                    walk_addr_next = LAST_A;
                    walk_left_next = TOTAL_N;
                    down_next      = 1'b1;
                    unique case (req.req_type)
                        bfs_pkg::REQ_LOAD:
                        begin
                            op_next       = bfs_pkg::REQ_LOAD;
                            bin_next      = req.load_value;
                            bcd_next      = '0;
                            conv_cnt_next = '0;
                            state_next    = bfs_pkg::ST_CONV;
                        end
                        bfs_pkg::REQ_MUL:
                        begin
                            op_next    = bfs_pkg::REQ_MUL;
                            state_next = bfs_pkg::ST_WALK;
                        end
                        bfs_pkg::REQ_DIV:
                        begin
                            op_next        = bfs_pkg::REQ_DIV;
                            walk_addr_next = '0;
                            down_next      = 1'b0;
                            if (req.factor == 4'd0)
                            begin
                                lz_next    = lz_reg;
                                state_next = bfs_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = bfs_pkg::ST_WALK;
                            end
                        end
                        bfs_pkg::REQ_ROUND:
                        begin
                            op_next = bfs_pkg::REQ_ROUND;
                            pa_next = pa_c[AW-1:0];
                            if (prec_c >= FRACT_C)
                            begin
                                lz_next    = lz_reg;
                                state_next = bfs_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = bfs_pkg::ST_WALK;
                            end
                        end
                        bfs_pkg::REQ_READ:
                        begin
                            lz_next       = lz_reg;
                            in_range_next = (pos_c < TOTAL_C);
                            state_next    = bfs_pkg::ST_READ;
                        end
                        default:
                        begin
                            lz_next    = lz_reg;
                            state_next = bfs_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            bfs_pkg::ST_CONV:
            begin
                // Double dabble, one binary bit a cycle.
                {bcd_next, bin_next} = {bfs_pkg::bcd_adjust(bcd_reg), bin_reg} << 1;
                conv_cnt_next = conv_cnt_reg + 1'b1;
                if (conv_cnt_reg == '1)
                begin
                    state_next = bfs_pkg::ST_WALK;
                end
            end
            bfs_pkg::ST_WALK:
            begin
                // Issue the next digit read.
                if (walk_left_reg != '0)
                begin
                    s1_valid_next  = 1'b1;
                    s1_addr_next   = walk_addr_reg;
                    walk_addr_next = down_reg ? walk_addr_reg - 1'b1 : walk_addr_reg + 1'b1;
                    walk_left_next = walk_left_reg - 1'b1;
                end
                // Write back the digit read in the previous cycle.
                if (s1_valid_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = s1_addr_reg;
                    wr_data    = s1_wdata;
                    carry_next = s1_carry;
                    if (op_reg == bfs_pkg::REQ_LOAD && s1_is_int)
                    begin
                        bcd_next = bcd_reg >> 4;
                    end
                    if (s1_is_int && s1_wdata != 4'd0 && s1_addr_reg < AW'(lz_reg))
                    begin
                        lz_next = LZW'(s1_addr_reg);
                    end
                end
                if (walk_left_reg == '0 && !s1_valid_reg)
                begin
                    state_next = bfs_pkg::ST_DONE;
                end
            end
            bfs_pkg::ST_READ:
            begin
                digit_next = in_range_reg ? rd_data_reg : 4'd0;
                state_next = bfs_pkg::ST_DONE;
            end
            bfs_pkg::ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_digit_next = digit_reg;
                    out_lz_next    = lz_ext[8:0];
                    state_next     = bfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfs_pkg::ST_CLEAR;
            walk_addr_reg <= '0;
            walk_left_reg <= TOTAL_N;
            down_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            lz_reg        <= LZ_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_addr_reg <= walk_addr_next;
            walk_left_reg <= walk_left_next;
            down_reg      <= down_next;
            s1_valid_reg  <= s1_valid_next;
            lz_reg        <= lz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        factor_reg    <= factor_next;
        pa_reg        <= pa_next;
        s1_addr_reg   <= s1_addr_next;
        carry_reg     <= carry_next;
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        conv_cnt_reg  <= conv_cnt_next;
        digit_reg     <= digit_next;
        in_range_reg  <= in_range_next;
        out_digit_reg <= out_digit_next;
        out_lz_reg    <= out_lz_next;
    end

`ifndef SYNTHESIS
    // A result appears only after the sequencer has finished a request.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bfs_pkg::ST_DONE))
        else $error("result raised outside the finishing state");

    // The digit store is never written while waiting for a request.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfs_pkg::ST_IDLE) |-> !wr_en)
        else $error("digit store written while idle");

    // The running remainder of a divide stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfs_pkg::ST_WALK && op_reg == bfs_pkg::REQ_DIV)
            |-> (carry_reg < factor_reg))
        else $error("divide remainder out of range");

    // The leading zero count never passes the lowest integer digit.
    a_lz_range: assert property (@(posedge clk) disable iff (!rst_n)
        lz_reg <= LZ_MAX)
        else $error("leading zero count out of range");
`endif

endmodule
